FILE: src/i8rq_pkg.sv
// Shared types, constants and helpers for the int8 block requantizer.
// Used by i8rq_round_unit and int8_block_requantizer_top; no dependencies.
package i8rq_pkg;

    // Block storage.
    localparam int BLOCK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(BLOCK_DEPTH);
    localparam int CNT_W       = $clog2(BLOCK_DEPTH + 1);

    // Field widths.
    localparam int ACC_W   = 32;
    localparam int EXP_W   = 8;
    localparam int Q_W     = 8;
    localparam int SHIFT_W = 5;
    localparam int MU_W    = 5;
    localparam int RANGE_W = 5;

    // Activation target width.
    localparam int ACT_BITS = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAD_BITS = 1'd1;
    localparam logic [MU_W-1:0]      GRAD_BITS_RST = 5'd5;

    // Modes.
    localparam logic MODE_ACT  = 1'b0;
    localparam logic MODE_GRAD = 1'b1;

    // Per-element operation of the rounding unit.
    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_ZERO  = 2'd0;
    localparam logic [OP_W-1:0] OP_PASS  = 2'd1;
    localparam logic [OP_W-1:0] OP_ROUND = 2'd2;

    // Stage enables from the sequencer to the rounding unit.
    typedef struct packed {
        logic load;
        logic finish;
    } ctrl_t;

    // Clamp a 33-bit signed value to signed 8 bits.
    function automatic logic signed [Q_W-1:0] sat8(input logic signed [ACC_W:0] v);
        logic signed [Q_W-1:0] res;
        if (v > 33'sd127) begin
            res = 8'sd127;
        end else if (v < -33'sd128) begin
            res = -8'sd128;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: src/i8rq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i8rq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/i8rq_round_unit.sv
// Shared two-stage rounding unit: pseudo-stochastic rounding, pass-through
// or zeroing of one element, saturated to int8. Depends on i8rq_pkg.
module i8rq_round_unit (
    input  logic                                aclk,
    input  i8rq_pkg::ctrl_t                     ctrl,
    input  logic [i8rq_pkg::OP_W-1:0]           op,
    input  logic [i8rq_pkg::SHIFT_W-1:0]        shift,
    input  logic signed [i8rq_pkg::ACC_W-1:0]   value,
    output logic signed [i8rq_pkg::Q_W-1:0]     q_value
);
    import i8rq_pkg::*;

    logic signed [ACC_W:0]   t_reg, t_next;
    logic [ACC_W-1:0]        r_reg, r_next;
    logic                    neg_reg;
    logic [OP_W-1:0]         op_reg;
    logic [SHIFT_W-1:0]      sh_reg;
    logic signed [ACC_W-1:0] val_reg;
    logic signed [Q_W-1:0]   q_reg, q_next;

    logic signed [ACC_W:0]   val_ext;
    logic [SHIFT_W-2:0]      half;
    logic [ACC_W-1:0]        q_part, p_part;
    logic signed [ACC_W:0]   adj, rounded;

    // First stage: split the value into quotient and remainder by the shift.
    always_comb begin
        val_ext = {value[ACC_W-1], value};
        t_next  = val_ext >>> shift;
        r_next  = value & ~({ACC_W{1'b1}} << shift);
    end

    // Second stage: compare the high and low parts of the remainder.
    always_comb begin
        half   = sh_reg[SHIFT_W-1:1];
        q_part = r_reg >> half;
        p_part = r_reg & ~({ACC_W{1'b1}} << half);
        if (sh_reg[0]) begin
            p_part = p_part << 1;
        end
        adj = '0;
        if (q_part > p_part) begin
            adj = neg_reg ? -33'sd1 : 33'sd1;
        end
        rounded = t_reg + adj;
        unique case (op_reg)
            OP_ROUND: q_next = sat8(rounded);
            OP_PASS:  q_next = sat8({val_reg[ACC_W-1], val_reg});
            default:  q_next = '0;
        endcase
    end

    // Stage registers.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            t_reg   <= t_next;
            r_reg   <= r_next;
            neg_reg <= value[ACC_W-1];
            op_reg  <= op;
            sh_reg  <= shift;
            val_reg <= value;
        end
        if (ctrl.finish) begin
            q_reg <= q_next;
        end
    end

    assign q_value = q_reg;

endmodule

FILE: src/int8_block_requantizer_top.sv
// Top level of the int8 block requantizer: block store, range search,
// drain sequencer and output register. Depends on i8rq_pkg, i8rq_ram, i8rq_round_unit.
//
//   Channel  Direction  Handshake              Contents
//   s_       in         s_tvalid / s_tready    acc_value, exp_in; tlast = is_last
//   m_       out        m_tvalid / m_tready    q_value, exp_out, shift_used; tlast = end_of_block
//   cfg_     in         cfg_valid / cfg_ready  register index and write data
//
// Loading accepts a word whenever s_tvalid is high in the load state. The word marked last
// starts a range search that shifts the peak magnitude less one by one bit per cycle, then a
// setup state; each stored element then passes through the read, load, finish and output
// states via the RAM read port and the two-stage rounding unit, and the output state waits
// while the output side stalls. The block takes no input word while it drains. Reset is synchronous, active low.
module int8_block_requantizer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream: [31:0] acc_value, [39:32] exp_in.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    // Result stream: [7:0] q_value, [15:8] exp_out, [20:16] shift_used, [23:21] zero.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    output logic        m_tlast,
    // Configuration writes.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [i8rq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [i8rq_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import i8rq_pkg::*;

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_LOAD  = 3'd0;
    localparam logic [ST_W-1:0] S_PREP  = 3'd1;
    localparam logic [ST_W-1:0] S_RANGE = 3'd2;
    localparam logic [ST_W-1:0] S_SETUP = 3'd3;
    localparam logic [ST_W-1:0] S_READ  = 3'd4;
    localparam logic [ST_W-1:0] S_LDU   = 3'd5;
    localparam logic [ST_W-1:0] S_FIN   = 3'd6;
    localparam logic [ST_W-1:0] S_OUT   = 3'd7;

    logic [ST_W-1:0]         state_reg, state_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [ACC_W-1:0]        max_reg, max_next;
    logic [ACC_W-1:0]        x_reg, x_next;
    logic [RANGE_W-1:0]      b_reg, b_next;
    logic signed [EXP_W-1:0] exp_in_reg, exp_in_next;
    logic signed [EXP_W-1:0] exp_out_reg, exp_out_next;
    logic [SHIFT_W-1:0]      used_reg, used_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_last_reg, m_last_next;
    logic                    mode_reg;
    logic [MU_W-1:0]         grad_bits_reg;

    logic                    s_fire, m_fire, cfg_fire;
    logic signed [ACC_W-1:0] s_value;
    logic signed [EXP_W-1:0] s_exp;
    logic [ACC_W-1:0]        s_mag;
    logic                    ram_we, ram_re;
    logic [ACC_W-1:0]        ram_rdata;
    logic signed [6:0]       sh_sgn;
    logic signed [EXP_W:0]   exp_sum;
    ctrl_t                   ru_ctrl;
    logic signed [Q_W-1:0]   ru_q;

    assign s_value  = s_tdata[ACC_W-1:0];
    assign s_exp    = s_tdata[ACC_W+EXP_W-1:ACC_W];
    assign s_tready = (state_reg == S_LOAD);
    assign s_fire   = s_tvalid && s_tready;
    assign m_fire   = m_valid_reg && m_tready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Magnitude of the incoming word; the most negative value maps to 2^31.
    assign s_mag  = s_value[ACC_W-1] ? (~s_value + 32'd1) : s_value;
    assign ram_we = s_fire && (fill_reg < CNT_W'(BLOCK_DEPTH));
    assign ram_re = (state_reg == S_READ);

    i8rq_ram #(
        .WIDTH (ACC_W),
        .DEPTH (BLOCK_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[ADDR_W-1:0]),
        .wr_data (s_value),
        .rd_en   (ram_re),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    assign ru_ctrl.load   = (state_reg == S_LDU);
    assign ru_ctrl.finish = (state_reg == S_FIN);

    i8rq_round_unit u_round (
        .aclk    (aclk),
        .ctrl    (ru_ctrl),
        .op      (op_reg),
        .shift   (used_reg),
        .value   (ram_rdata),
        .q_value (ru_q)
    );

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        idx_next     = idx_reg;
        max_next     = max_reg;
        x_next       = x_reg;
        b_next       = b_reg;
        exp_in_next  = exp_in_reg;
        exp_out_next = exp_out_reg;
        used_next    = used_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        m_last_next  = m_last_reg;
        sh_sgn       = '0;
        exp_sum      = '0;

        unique case (state_reg)
            S_LOAD: begin
                if (s_fire) begin
                    if (ram_we) begin
                        fill_next = fill_reg + CNT_W'(1);
                        if (s_mag > max_reg) begin
                            max_next = s_mag;
                        end
                    end
                    if (s_tlast) begin
                        exp_in_next = s_exp;
                        state_next  = S_PREP;
                    end
                end
            end
            S_PREP: begin
                // Range of max is the bit length of max - 1, zero for max of zero.
                x_next     = (max_reg == '0) ? '0 : (max_reg - 32'd1);
                b_next     = '0;
                state_next = S_RANGE;
            end
            S_RANGE: begin
                if (x_reg != '0) begin
                    x_next = x_reg >> 1;
                    b_next = b_reg + RANGE_W'(1);
                end else begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP: begin
                // Choose the block's operation, shift and exponent.
                if (mode_reg == MODE_ACT) begin
                    sh_sgn = $signed({2'b00, b_reg}) - 7'sd7;
                    if (sh_sgn > 7'sd0) begin
                        exp_sum      = $signed({exp_in_reg[EXP_W-1], exp_in_reg})
                                       + $signed({4'b0000, sh_sgn[SHIFT_W-1:0]});
                        used_next    = sh_sgn[SHIFT_W-1:0];
                        exp_out_next = sat8({{(ACC_W-EXP_W){exp_sum[EXP_W]}}, exp_sum});
                        op_next      = OP_ROUND;
                    end else begin
                        used_next    = '0;
                        exp_out_next = exp_in_reg;
                        op_next      = OP_PASS;
                    end
                end else begin
                    sh_sgn       = $signed({2'b00, b_reg}) - $signed({2'b00, grad_bits_reg});
                    used_next    = '0;
                    exp_out_next = '0;
                    if (b_reg == '0) begin
                        op_next = OP_ZERO;
                    end else if (sh_sgn >= 7'sd1) begin
                        used_next    = sh_sgn[SHIFT_W-1:0];
                        exp_out_next = {3'b000, sh_sgn[SHIFT_W-1:0]};
                        op_next      = OP_ROUND;
                    end else begin
                        op_next = OP_PASS;
                    end
                end
                idx_next   = '0;
                state_next = S_READ;
            end
            S_READ: begin
                state_next = S_LDU;
            end
            S_LDU: begin
                state_next = S_FIN;
            end
            S_FIN: begin
                m_valid_next = 1'b1;
                m_last_next  = (idx_reg + CNT_W'(1) == fill_reg);
                state_next   = S_OUT;
            end
            S_OUT: begin
                if (m_fire) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        fill_next  = '0;
                        max_next   = '0;
                        state_next = S_LOAD;
                    end else begin
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_LOAD;
            fill_reg      <= '0;
            max_reg       <= '0;
            m_valid_reg   <= 1'b0;
            mode_reg      <= MODE_ACT;
            grad_bits_reg <= GRAD_BITS_RST;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
            if (cfg_fire) begin
                if (cfg_index == CFG_MODE) begin
                    mode_reg <= cfg_data[0];
                end else if (cfg_index == CFG_GRAD_BITS) begin
                    grad_bits_reg <= cfg_data[MU_W-1:0];
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        x_reg       <= x_next;
        b_reg       <= b_next;
        exp_in_reg  <= exp_in_next;
        exp_out_reg <= exp_out_next;
        used_reg    <= used_next;
        op_reg      <= op_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, used_reg, exp_out_reg, ru_q};

    // Input and output are never open at the same time.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while a result word is pending");

    // The fill count never exceeds the store depth.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(BLOCK_DEPTH))
        else $error("fill count beyond store depth");

    // Delivering the final word of a block empties the store.
    a_block_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (fill_reg == '0 && max_reg == '0 && s_tready))
        else $error("store not cleared after end of block");

    // A result word only follows the finishing stage of the rounding unit.
    a_out_after_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == S_FIN))
        else $error("result word raised outside the finishing stage");

endmodule

FILE: bench/int8_block_requantizer_top_tb.sv
// Self-checking bench for int8_block_requantizer_top: directed table, then random blocks.
// Depends on i8rq_pkg and the block's RTL; expected words come from a predictor kept here.
`timescale 1ns / 1ps

module int8_block_requantizer_top_tb;
    import i8rq_pkg::*;

    // One requantized output word as the block should present it.
    typedef struct packed {
        logic signed [7:0] q;
        logic signed [7:0] e;
        logic [4:0]        sh;
        logic              eob;
    } res_t;

    // One row of the directed table: a register write or an input word.
    typedef struct {
        bit                 is_cfg;
        logic [0:0]         idx;
        logic [4:0]         val;
        logic signed [31:0] acc;
        logic signed [7:0]  ex;
        bit                 last;
        bit                 typed;
        res_t               want;
    } step_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    // Input stream: [31:0] acc_value, [39:32] exp_in.
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    // Result stream: [7:0] q_value, [15:8] exp_out, [20:16] shift_used, [23:21] zero.
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Predictor state: the block being collected and the register copies.
    longint     blk_vals[BLOCK_DEPTH];
    int         blk_fill = 0;
    longint     blk_peak = 0;
    logic       cur_mode = MODE_ACT;
    logic [4:0] cur_mu = GRAD_BITS_RST;

    res_t  pending_words[$];
    step_t plan[$];
    int    failures = 0;
    bit    no_gaps = 1'b0;

    int8_block_requantizer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic res_t mk_res(int q, int e, int sh, bit eob);
        res_t r;
        r.q = 8'(q);
        r.e = 8'(e);
        r.sh = 5'(sh);
        r.eob = eob;
        return r;
    endfunction

    function automatic step_t word_row(longint acc, int ex, bit last, bit typed = 0,
                                       res_t want = '0);
        step_t s;
        s.is_cfg = 0;
        s.idx = '0;
        s.val = '0;
        s.acc = 32'(acc);
        s.ex = 8'(ex);
        s.last = last;
        s.typed = typed;
        s.want = want;
        return s;
    endfunction

    function automatic step_t cfg_row(logic [0:0] idx, logic [4:0] val);
        step_t s;
        s = word_row(0, 0, 0);
        s.is_cfg = 1;
        s.idx = idx;
        s.val = val;
        return s;
    endfunction

    function automatic logic signed [7:0] clamp8(longint v);
        if (v > 127) return 8'sd127;
        if (v < -128) return -8'sd128;
        return v[7:0];
    endfunction

    // Number of bits needed for peak-1, i.e. ceil(log2(peak)); zero for an all-zero block.
    function automatic int range_bits(longint peak);
        longint x;
        int     n;
        n = 0;
        if (peak == 0) return 0;
        x = peak - 1;
        while (x != 0) begin
            n++;
            x = x >>> 1;
        end
        return n;
    endfunction

    // Split v into t*2^s + r, then compare the upper and lower halves of r
    // to decide whether to step away from zero.
    function automatic longint stochastic_round(longint v, int s);
        longint t;
        longint r;
        longint q;
        longint p;
        int     h;
        t = v >>> s;
        r = v - (t <<< s);
        h = s >> 1;
        q = r >> h;
        p = r & ((longint'(1) << h) - 1);
        if (s % 2 == 1) p = p << 1;
        if (q <= p) return t;
        return t + ((v > 0) ? 1 : ((v < 0) ? -1 : 0));
    endfunction

    // Absorb one accepted word; on the last word of a block queue its outputs.
    task automatic requantize_word(logic signed [31:0] acc, logic signed [7:0] ex, bit last,
                                   bit typed, res_t want);
        longint x;
        longint mag;
        int     b;
        int     sh;
        int     used;
        logic signed [7:0] eo;
        bit     zero_all;
        res_t   r;
        x = acc;
        zero_all = 0;
        if (blk_fill < BLOCK_DEPTH) begin
            blk_vals[blk_fill] = x;
            blk_fill++;
            mag = (x < 0) ? -x : x;
            if (mag > blk_peak) blk_peak = mag;
        end
        if (!last) return;
        b = range_bits(blk_peak);
        if (cur_mode == MODE_ACT) begin
            sh = b - ACT_BITS;
            if (sh > 0) begin
                used = sh;
                eo = clamp8(longint'(ex) + sh);
            end else begin
                used = 0;
                eo = ex;
            end
        end else begin
            sh = b - int'(cur_mu);
            used = 0;
            eo = 0;
            zero_all = (b == 0);
            if (!zero_all && sh >= 1) begin
                used = sh;
                eo = 8'(sh);
            end
        end
        if (typed) begin
            pending_words.push_back(want);
        end else begin
            for (int k = 0; k < blk_fill; k++) begin
                if (zero_all) r.q = 0;
                else if (used > 0) r.q = clamp8(stochastic_round(blk_vals[k], used));
                else r.q = clamp8(blk_vals[k]);
                r.e = eo;
                r.sh = 5'(used);
                r.eob = (k == blk_fill - 1);
                pending_words.push_back(r);
            end
        end
        blk_fill = 0;
        blk_peak = 0;
    endtask

    task automatic note_failure(string what);
        failures++;
        if (failures <= 10) $display("%0t: %s", $realtime, what);
    endtask

    // Offer one input word, with random gaps ahead of it, and predict once it is taken.
    task automatic send_word(logic signed [31:0] acc, logic signed [7:0] ex, bit last,
                             bit typed, res_t want);
        while (!no_gaps && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ex, acc};
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requantize_word(acc, ex, last, typed, want);
    endtask

    // Let the block finish every pending word and go quiet.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_register(logic [0:0] idx, logic [4:0] val);
        drain_block();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_MODE) cur_mode = val[0];
        else cur_mu = val;
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Random accumulator value of up to wmax significant bits, either sign.
    function automatic logic [31:0] draw_acc(int wmax);
        int         w;
        int         pick;
        logic [31:0] v;
        pick = $urandom_range(0, 19);
        if (wmax == 32 && pick == 0) return 32'h8000_0000;
        if (wmax == 32 && pick == 1) return 32'h7fff_ffff;
        w = $urandom_range(0, wmax);
        v = (w == 0) ? 32'd0 : ($urandom & (32'hffff_ffff >> (32 - w)));
        if ($urandom_range(0, 1) == 1) v = -v;
        return v;
    endfunction

    // Output side: random backpressure, compare each taken word with the oldest prediction.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        m_tready <= no_gaps || ($urandom_range(0, 99) >= 28);
        if (aresetn && m_tvalid && m_tready) begin
            got.q = m_tdata[7:0];
            got.e = m_tdata[15:8];
            got.sh = m_tdata[20:16];
            got.eob = m_tlast;
            if (pending_words.size() == 0) begin
                note_failure($sformatf("unexpected word q=%0d exp=%0d shift=%0d last=%0b",
                                       got.q, got.e, got.sh, got.eob));
            end else begin
                want = pending_words.pop_front();
                if (got != want || m_tdata[23:21] != 3'd0) begin
                    note_failure($sformatf(
                        "mismatch: expected q=%0d exp=%0d shift=%0d last=%0b, got %s",
                        want.q, want.e, want.sh, want.eob,
                        $sformatf("q=%0d exp=%0d shift=%0d last=%0b pad=%0d",
                                  got.q, got.e, got.sh, got.eob, m_tdata[23:21])));
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int sent;
        int blk;
        int len;
        int wmax;
        int pick;

        // Activation mode from reset: pass-through, saturation, full-scale rounding.
        plan.push_back(word_row(5, 3, 1, 1, mk_res(5, 3, 0, 1)));
        plan.push_back(word_row(128, -7, 1, 1, mk_res(127, -7, 0, 1)));
        plan.push_back(word_row(-128, 0, 0));
        plan.push_back(word_row(-3, 0, 1));
        plan.push_back(word_row(32'sh8000_0000, 127, 1, 1, mk_res(-128, 127, 24, 1)));
        plan.push_back(word_row(32'sh7fff_ffff, -128, 1, 1, mk_res(127, -104, 24, 1)));
        plan.push_back(word_row(1000, -5, 0));
        plan.push_back(word_row(-1000, -5, 0));
        plan.push_back(word_row(37, -5, 0));
        plan.push_back(word_row(0, -5, 0));
        plan.push_back(word_row(999, -5, 1));
        // Gradient mode with the reset width: all zero, small range, rounding.
        plan.push_back(cfg_row(CFG_MODE, {4'd0, MODE_GRAD}));
        plan.push_back(word_row(0, 50, 1, 1, mk_res(0, 0, 0, 1)));
        plan.push_back(word_row(20, 9, 1, 1, mk_res(20, 0, 0, 1)));
        plan.push_back(word_row(1000, 2, 0));
        plan.push_back(word_row(-777, 2, 1));
        // Widest target: even the most negative input passes through, saturated.
        plan.push_back(cfg_row(CFG_GRAD_BITS, 5'd31));
        plan.push_back(word_row(32'sh8000_0000, 0, 1, 1, mk_res(-128, 0, 0, 1)));
        // Zero target width: the shift equals the range.
        plan.push_back(cfg_row(CFG_GRAD_BITS, 5'd0));
        plan.push_back(word_row(2, 0, 1, 1, mk_res(1, 1, 1, 1)));
        plan.push_back(word_row(-3, 0, 0));
        plan.push_back(word_row(7, 0, 1));
        plan.push_back(cfg_row(CFG_GRAD_BITS, 5'd1));
        plan.push_back(word_row(-100, 4, 0));
        plan.push_back(word_row(55, 4, 1));
        plan.push_back(cfg_row(CFG_MODE, {4'd0, MODE_ACT}));
        plan.push_back(cfg_row(CFG_GRAD_BITS, 5'd5));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg) set_register(plan[i].idx, plan[i].val);
            else send_word(plan[i].acc, plan[i].ex, plan[i].last, plan[i].typed, plan[i].want);
        end

        // Random blocks with occasional register changes; every eighth block fills the store and may overfill it.
        sent = 0;
        blk = 0;
        while (sent < 230) begin
            pick = $urandom_range(0, 5);
            if (pick == 0) begin
                set_register(CFG_MODE,
                             {4'd0, ($urandom_range(0, 1) == 1) ? MODE_GRAD : MODE_ACT});
            end else if (pick == 1) begin
                case ($urandom_range(0, 3))
                    0: set_register(CFG_GRAD_BITS, 5'd0);
                    1: set_register(CFG_GRAD_BITS, 5'd1);
                    2: set_register(CFG_GRAD_BITS, 5'd31);
                    default: set_register(CFG_GRAD_BITS, 5'($urandom_range(0, 31)));
                endcase
            end
            len = (blk % 8 == 4) ? $urandom_range(BLOCK_DEPTH, BLOCK_DEPTH + 4)
                                 : $urandom_range(1, 10);
            wmax = $urandom_range(0, 32);
            for (int k = 0; k < len; k++) begin
                no_gaps = (sent >= 70 && sent < 130);
                send_word(draw_acc(wmax), 8'($urandom_range(0, 255)), k == len - 1, 0, '0);
                if (k < BLOCK_DEPTH) sent++;
            end
            blk++;
        end
        no_gaps = 1'b0;

        drain_block();
        repeat (40) @(posedge aclk);
        if (pending_words.size() != 0) begin
            note_failure($sformatf("%0d expected words never arrived", pending_words.size()));
        end
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
